// ===== rtl/core/plat_pkg.sv =====
// Package for the polygon transform and point test block.
// Holds the shared widths, action and status codes, and the cell control type.
// No dependencies.
package plat_pkg;

  localparam int COORD_W       = 32;
  localparam int TRIG_W        = 16;
  localparam int MAX_VERTICES  = 16;
  localparam int MIN_POLY      = 3;
  localparam int FRAC_SHIFT    = 14;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_APPEND    = 3'd1,
    ACT_TRANSLATE = 3'd2,
    ACT_MOVE_TO   = 3'd3,
    ACT_SET_ANCH  = 3'd4,
    ACT_ROTATE    = 3'd5,
    ACT_TEST      = 3'd6,
    ACT_READ      = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef struct packed {
    logic load_in;
    logic load_proc;
    logic load_nb;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/plat_cell.sv =====
// One vertex cell of the vertex ring.
// Holds one x/y pair and loads from the input, the processing unit or its neighbor.
// Depends on plat_pkg.
module plat_cell (
  input  logic                             clk_i,
  input  plat_pkg::cell_ctrl_t             ctrl_i,
  input  logic [plat_pkg::COORD_W-1:0]     in_x_i,
  input  logic [plat_pkg::COORD_W-1:0]     in_y_i,
  input  logic [plat_pkg::COORD_W-1:0]     proc_x_i,
  input  logic [plat_pkg::COORD_W-1:0]     proc_y_i,
  input  logic [plat_pkg::COORD_W-1:0]     nb_x_i,
  input  logic [plat_pkg::COORD_W-1:0]     nb_y_i,
  output logic [plat_pkg::COORD_W-1:0]     x_o,
  output logic [plat_pkg::COORD_W-1:0]     y_o
);
  import plat_pkg::*;

  logic [COORD_W-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      x_q <= in_x_i;
      y_q <= in_y_i;
    end else if (ctrl_i.load_proc) begin
      x_q <= proc_x_i;
      y_q <= proc_y_i;
    end else if (ctrl_i.load_nb) begin
      x_q <= nb_x_i;
      y_q <= nb_y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ===== rtl/core/polygon_transform_and_point_test.sv =====
// Polygon vertex store with translate, rotate and even-odd point test.
// Depends on plat_pkg and plat_cell.
//
// Vertices live in a ring of cells; walking operations rotate the held
// vertices through one shared processing unit at cell zero and back in at the
// tail, so the ring is back in order after count steps. Clear, append, set
// anchor and read are answered directly from the idle state. Translate and
// move-to walk the ring once; rotate and the point test pass each vertex
// through a difference stage, a multiply stage and an accumulate stage.
// One transaction is worked on at a time, and a result that waits on a stalled
// output holds off the next transaction until it has been taken.
module polygon_transform_and_point_test #(
  parameter int MaxVertices = plat_pkg::MAX_VERTICES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        action_i,
  input  logic [3:0]                        vertex_index_i,
  input  logic [plat_pkg::COORD_W-1:0]      coord_x_i,
  input  logic [plat_pkg::COORD_W-1:0]      coord_y_i,
  input  logic [plat_pkg::TRIG_W-1:0]       rot_cos_i,
  input  logic [plat_pkg::TRIG_W-1:0]       rot_sin_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_res_o,
  output logic [plat_pkg::COORD_W-1:0]      vertex_x_o,
  output logic [plat_pkg::COORD_W-1:0]      vertex_y_o,
  output logic [4:0]                        vertex_count_o,
  output logic [1:0]                        status_o
);
  import plat_pkg::*;

  localparam int CW = $clog2(MaxVertices + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_PH0  = 6'b000100,
    S_PH1  = 6'b001000,
    S_PH2  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  action_e op_q;
  logic [CW-1:0] count_q, count_d, k_q, k_d;
  logic [COORD_W-1:0] anc_x_q, anc_y_q, anc_x_d, anc_y_d;
  logic [COORD_W-1:0] off_x_q, off_y_q, pt_x_q, pt_y_q;
  logic [TRIG_W-1:0] cos_q, sin_q;
  logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic inside_q, inside_d;

  logic out_valid_q, out_inside_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [CW-1:0] out_count_q;
  status_e out_status_q;

  logic out_free, accept, shift_en, app_we, res_now;
  logic [COORD_W-1:0] proc_x, proc_y, head_x, head_y;
  logic [COORD_W-1:0] cx [MaxVertices];
  logic [COORD_W-1:0] cy [MaxVertices];

  logic [COORD_W-1:0] rd_x, rd_y;
  logic rd_ok;
  status_e res_status;
  logic [COORD_W-1:0] res_x, res_y;

  // Arithmetic stage registers.
  logic signed [COORD_W-1:0] rdx_q, rdy_q;
  logic signed [COORD_W:0] ta_q, tb_q, td_q, tt_q;
  logic tcross_q;
  logic signed [COORD_W+TRIG_W-1:0] rp0_q, rp1_q, rp2_q, rp3_q;
  logic signed [2*COORD_W+1:0] m0_q, m1_q;

  logic [COORD_W-1:0] cur_x, cur_y;
  logic signed [COORD_W:0] e_d, e_t;
  logic signed [COORD_W+TRIG_W:0] sum_x, sum_y;
  logic [COORD_W-1:0] rot_x, rot_y;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign head_x     = cx[0];
  assign head_y     = cy[0];
  assign app_we     = accept && (action_e'(action_i) == ACT_APPEND) &&
                      (count_q < CW'(MaxVertices));

  // Vertex ring.
  for (genvar i = 0; i < MaxVertices; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [COORD_W-1:0] nbx, nby;
    assign ctrl.load_in   = app_we && (count_q == CW'(i));
    assign ctrl.load_proc = shift_en && (CW'(i) + CW'(1) == count_q);
    assign ctrl.load_nb   = shift_en && (CW'(i) + CW'(1) < count_q);
    if (i == MaxVertices - 1) begin : g_last
      assign nbx = '0;
      assign nby = '0;
    end else begin : g_mid
      assign nbx = cx[i+1];
      assign nby = cy[i+1];
    end
    plat_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .in_x_i   (coord_x_i),
      .in_y_i   (coord_y_i),
      .proc_x_i (proc_x),
      .proc_y_i (proc_y),
      .nb_x_i   (nbx),
      .nb_y_i   (nby),
      .x_o      (cx[i]),
      .y_o      (cy[i])
    );
  end

  always_comb begin
    rd_x = '0;
    rd_y = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      if (int'(vertex_index_i) == i) begin
        rd_x = cx[i];
        rd_y = cy[i];
      end
    end
    rd_ok = int'(vertex_index_i) < int'(count_q);
  end

  // Per-vertex arithmetic.
  always_comb begin
    cur_x = (k_q == count_q) ? first_x_q : head_x;
    cur_y = (k_q == count_q) ? first_y_q : head_y;
    e_d   = {prev_y_q[COORD_W-1], prev_y_q} - {cur_y[COORD_W-1], cur_y};
    e_t   = {pt_y_q[COORD_W-1], pt_y_q} - {cur_y[COORD_W-1], cur_y};
    sum_x = {rp0_q[COORD_W+TRIG_W-1], rp0_q} - {rp1_q[COORD_W+TRIG_W-1], rp1_q};
    sum_y = {rp2_q[COORD_W+TRIG_W-1], rp2_q} + {rp3_q[COORD_W+TRIG_W-1], rp3_q};
    rot_x = sum_x[COORD_W+FRAC_SHIFT-1:FRAC_SHIFT] + anc_x_q;
    rot_y = sum_y[COORD_W+FRAC_SHIFT-1:FRAC_SHIFT] + anc_y_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PH0) begin
      rdx_q    <= $signed(head_x - anc_x_q);
      rdy_q    <= $signed(head_y - anc_y_q);
      tcross_q <= ($signed(cur_y) > $signed(pt_y_q)) !=
                  ($signed(prev_y_q) > $signed(pt_y_q));
      ta_q     <= $signed({pt_x_q[COORD_W-1], pt_x_q}) - $signed({cur_x[COORD_W-1], cur_x});
      tb_q     <= $signed({prev_x_q[COORD_W-1], prev_x_q}) -
                  $signed({cur_x[COORD_W-1], cur_x});
      td_q     <= e_d[COORD_W] ? -e_d : e_d;
      tt_q     <= e_d[COORD_W] ? -e_t : e_t;
    end
    if (state_q == S_PH1) begin
      rp0_q <= rdx_q * $signed(cos_q);
      rp1_q <= rdy_q * $signed(sin_q);
      rp2_q <= rdx_q * $signed(sin_q);
      rp3_q <= rdy_q * $signed(cos_q);
      m0_q  <= ta_q * td_q;
      m1_q  <= tb_q * tt_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    k_d      = k_q;
    anc_x_d  = anc_x_q;
    anc_y_d  = anc_y_q;
    inside_d = inside_q;
    shift_en = 1'b0;
    proc_x   = head_x;
    proc_y   = head_y;
    res_now  = 1'b0;
    res_status = ST_OK;
    res_x    = '0;
    res_y    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          k_d      = '0;
          inside_d = 1'b0;
          unique case (action_e'(action_i))
            ACT_CLEAR: begin
              count_d = '0;
              res_now = 1'b1;
            end
            ACT_APPEND: begin
              res_now = 1'b1;
              if (app_we) count_d = count_q + CW'(1);
              else res_status = ST_FULL;
            end
            ACT_SET_ANCH: begin
              anc_x_d = coord_x_i;
              anc_y_d = coord_y_i;
              res_now = 1'b1;
            end
            ACT_READ: begin
              res_now = 1'b1;
              if (rd_ok) begin
                res_x = rd_x;
                res_y = rd_y;
              end else begin
                res_status = ST_BAD_IDX;
              end
            end
            ACT_TRANSLATE, ACT_MOVE_TO: begin
              if (action_e'(action_i) == ACT_TRANSLATE) begin
                anc_x_d = anc_x_q + coord_x_i;
                anc_y_d = anc_y_q + coord_y_i;
              end else begin
                anc_x_d = coord_x_i;
                anc_y_d = coord_y_i;
              end
              if (count_q == '0) res_now = 1'b1;
              else state_d = S_WALK;
            end
            ACT_ROTATE: begin
              if (count_q == '0) res_now = 1'b1;
              else state_d = S_PH0;
            end
            default: begin
              if (count_q < CW'(MIN_POLY)) res_now = 1'b1;
              else state_d = S_PH0;
            end
          endcase
        end
      end
      S_WALK: begin
        shift_en = 1'b1;
        proc_x   = head_x + off_x_q;
        proc_y   = head_y + off_y_q;
        k_d      = k_q + CW'(1);
        if (k_q + CW'(1) == count_q) state_d = S_DONE;
      end
      S_PH0: state_d = S_PH1;
      S_PH1: state_d = S_PH2;
      S_PH2: begin
        if (op_q == ACT_ROTATE) begin
          shift_en = 1'b1;
          proc_x   = rot_x;
          proc_y   = rot_y;
          k_d      = k_q + CW'(1);
          state_d  = (k_q + CW'(1) == count_q) ? S_DONE : S_PH0;
        end else begin
          if ((k_q != '0) && tcross_q && (m0_q < m1_q)) inside_d = !inside_q;
          if (k_q == count_q) begin
            state_d = S_DONE;
          end else begin
            shift_en = 1'b1;
            k_d      = k_q + CW'(1);
            state_d  = S_PH0;
          end
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      anc_x_q     <= '0;
      anc_y_q     <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      k_q      <= k_d;
      anc_x_q  <= anc_x_d;
      anc_y_q  <= anc_y_d;
      inside_q <= inside_d;
      if (res_now || (state_q == S_DONE && out_free)) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= action_e'(action_i);
      pt_x_q  <= coord_x_i;
      pt_y_q  <= coord_y_i;
      cos_q   <= rot_cos_i;
      sin_q   <= rot_sin_i;
      if (action_e'(action_i) == ACT_MOVE_TO) begin
        off_x_q <= coord_x_i - anc_x_q;
        off_y_q <= coord_y_i - anc_y_q;
      end else begin
        off_x_q <= coord_x_i;
        off_y_q <= coord_y_i;
      end
    end
    if (state_q == S_PH2 && op_q == ACT_TEST && k_q != count_q) begin
      prev_x_q <= head_x;
      prev_y_q <= head_y;
      if (k_q == '0) begin
        first_x_q <= head_x;
        first_y_q <= head_y;
      end
    end
    if (res_now) begin
      out_inside_q <= 1'b0;
      out_x_q      <= res_x;
      out_y_q      <= res_y;
      out_count_q  <= count_d;
      out_status_q <= res_status;
    end else if (state_q == S_DONE && out_free) begin
      out_inside_q <= inside_q;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_count_q  <= count_q;
      out_status_q <= ST_OK;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign inside_res_o   = out_inside_q;
  assign vertex_x_o     = out_x_q;
  assign vertex_y_o     = out_y_q;
  assign vertex_count_o = 5'(out_count_q);
  assign status_o       = out_status_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxVertices)) else $error("vertex count above table size");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("transaction accepted while busy");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (k_q <= count_q)) else $error("walk index past count");

endmodule
